// File: sv/thce_pkg.sv
// Shared types and constants of the tree hash code encoder.
package thce_pkg;

  // Tree geometry
  localparam int MaxDepth = 4;
  localparam int NumNodes = (1 << MaxDepth) - 1;
  localparam int CodeW    = 4;

  // Field widths
  localparam int FeatW    = 16;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegThrLevels01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThrLevel2   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThrLevel3   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLevelScales = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevelOffs   = 3'd4;

  // Reset values
  localparam logic [CfgDataW-1:0] ScalesReset = 64'h1000_1000_1000_1000;

  // Decoded configuration: node n of level l sits at byte (2^l - 1) + n
  typedef struct packed {
    logic [NumNodes-1:0][ByteW-1:0] thr;
    logic [MaxDepth-1:0][FeatW-1:0] scale;
    logic [MaxDepth-1:0][FeatW-1:0] offset;
  } cfg_t;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  typedef logic [MaxDepth-1:0][ByteW-1:0] byte_vec_t;

endpackage

// File: sv/thce_in_if.sv
// Input channel: four Q8.8 features per word.
interface thce_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [thce_pkg::FeatW-1:0]   feature_0;
  logic signed [thce_pkg::FeatW-1:0]   feature_1;
  logic signed [thce_pkg::FeatW-1:0]   feature_2;
  logic signed [thce_pkg::FeatW-1:0]   feature_3;

  modport source (output valid, feature_0, feature_1, feature_2, feature_3, input ready);
  modport sink   (input valid, feature_0, feature_1, feature_2, feature_3, output ready);
endinterface

// File: sv/thce_out_if.sv
// Result channel: one leaf code per word.
interface thce_out_if;
  logic                         valid;
  logic                         ready;
  logic [thce_pkg::CodeW-1:0]   code;

  modport source (output valid, code, input ready);
  modport sink   (input valid, code, output ready);
endinterface

// File: sv/thce_cfg_if.sv
// Configuration write channel: register index and write data.
interface thce_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [thce_pkg::CfgIdxW-1:0]    index;
  logic [thce_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/tree_hash_code_encoder.sv
// Pipeline stages from input word acceptance to out_chan.valid: multiply, round/clamp,
// node compare, path select with output register.
// Throughput: one word per cycle; each stage holds under back-pressure and bubbles collapse.
// The configuration port takes a write word every cycle.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module tree_hash_code_encoder #(
  parameter int TREE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  thce_in_if.sink     in_chan,
  thce_out_if.source  out_chan,
  thce_cfg_if.sink    cfg_chan
);

  thce_pkg::cfg_t      cfg;
  thce_pkg::stage_en_t en;
  thce_pkg::byte_vec_t qbytes;
  logic [3:0]          valid_r;
  logic [3:0]          valid_nxt;
  logic [thce_pkg::MaxDepth-1:0][thce_pkg::FeatW-1:0] feat;

  // Configuration registers
  thce_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Stage k loads when it is empty or its contents move on
  assign en.s4 = !valid_r[3] || out_chan.ready;
  assign en.s3 = !valid_r[2] || en.s4;
  assign en.s2 = !valid_r[1] || en.s3;
  assign en.s1 = !valid_r[0] || en.s2;

  assign in_chan.ready = en.s1;

  // Advance valid bits alongside the data
  always_comb begin
    valid_nxt = valid_r;
    if (en.s1) valid_nxt[0] = in_chan.valid;
    if (en.s2) valid_nxt[1] = valid_r[0];
    if (en.s3) valid_nxt[2] = valid_r[1];
    if (en.s4) valid_nxt[3] = valid_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign feat[0] = in_chan.feature_0;
  assign feat[1] = in_chan.feature_1;
  assign feat[2] = in_chan.feature_2;
  assign feat[3] = in_chan.feature_3;

  // One quantizer lane per tree level in use
  for (genvar l = 0; l < thce_pkg::MaxDepth; l++) begin : g_lane
    if (l < TREE_DEPTH) begin : g_used
      thce_quant u_quant (
        .clk     (clk),
        .en      (en),
        .feature ($signed(feat[l])),
        .scale   ($signed(cfg.scale[l])),
        .offset  ($signed(cfg.offset[l])),
        .qbyte   (qbytes[l])
      );
    end else begin : g_unused
      assign qbytes[l] = '0;
    end
  end

  // Node compares and path select
  thce_tree #(
    .TREE_DEPTH (TREE_DEPTH)
  ) u_tree (
    .clk    (clk),
    .en     (en),
    .qbytes (qbytes),
    .thr    (cfg.thr),
    .code   (out_chan.code)
  );

  assign out_chan.valid = valid_r[3];

endmodule

// File: sv/thce_cfg.sv
// Configuration register file of the encoder.
module thce_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  thce_cfg_if.sink             cfg_chan,
  output thce_pkg::cfg_t       cfg
);

  logic [23:0] thr01_r;
  logic [31:0] thr2_r;
  logic [63:0] thr3_r;
  logic [63:0] scales_r;
  logic [63:0] offsets_r;

  // Always take a write word; unknown indexes are dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr01_r   <= '0;
      thr2_r    <= '0;
      thr3_r    <= '0;
      scales_r  <= thce_pkg::ScalesReset;
      offsets_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        thce_pkg::RegThrLevels01: thr01_r   <= cfg_chan.data[23:0];
        thce_pkg::RegThrLevel2:   thr2_r    <= cfg_chan.data[31:0];
        thce_pkg::RegThrLevel3:   thr3_r    <= cfg_chan.data;
        thce_pkg::RegLevelScales: scales_r  <= cfg_chan.data;
        thce_pkg::RegLevelOffs:   offsets_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Flatten thresholds so node n of level l is byte (2^l - 1) + n
  assign cfg.thr    = {thr3_r, thr2_r, thr01_r};
  assign cfg.scale  = scales_r;
  assign cfg.offset = offsets_r;

endmodule

// File: sv/thce_quant.sv
// Quantizer lane: Q8.8 feature to saturated signed byte over two stages.
module thce_quant (
  input  logic                               clk,
  input  thce_pkg::stage_en_t                en,
  input  logic signed [thce_pkg::FeatW-1:0]  feature,
  input  logic signed [thce_pkg::FeatW-1:0]  scale,
  input  logic signed [thce_pkg::FeatW-1:0]  offset,
  output logic signed [thce_pkg::ByteW-1:0]  qbyte
);

  logic signed [31:0] prod_r;
  logic signed [33:0] sum;
  logic signed [13:0] q;
  logic signed [7:0]  qbyte_nxt;
  logic signed [7:0]  qbyte_r;

  // Stage 1: Q8.8 times Q4.12 gives Q12.20
  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= feature * scale;
    end
  end

  // Stage 2: add offset aligned to Q.20, round half up, clamp to a byte
  always_comb begin
    sum = 34'(prod_r) + (34'(offset) <<< 12) + 34'sd524288;
    q   = 14'(sum >>> 20);
    if (q > 14'sd127) begin
      qbyte_nxt = 8'sd127;
    end else if (q < -14'sd128) begin
      qbyte_nxt = -8'sd128;
    end else begin
      qbyte_nxt = 8'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      qbyte_r <= qbyte_nxt;
    end
  end

  assign qbyte = qbyte_r;

endmodule

// File: sv/thce_tree.sv
// Tree walk: compare every node of the levels in use in parallel, then select the leaf path.
module thce_tree #(
  parameter int TREE_DEPTH = 4
) (
  input  logic                                            clk,
  input  thce_pkg::stage_en_t                             en,
  input  thce_pkg::byte_vec_t                             qbytes,
  input  logic [thce_pkg::NumNodes-1:0][thce_pkg::ByteW-1:0] thr,
  output logic [thce_pkg::CodeW-1:0]                      code
);

  logic [thce_pkg::NumNodes-1:0] cmp_nxt;
  logic [thce_pkg::NumNodes-1:0] cmp_r;
  logic [thce_pkg::CodeW-1:0]    code_nxt;
  logic [thce_pkg::CodeW-1:0]    code_r;

  // Stage 3: decision bit of every node of the levels in use
  always_comb begin
    cmp_nxt = '0;
    for (int l = 0; l < thce_pkg::MaxDepth; l++) begin
      for (int n = 0; n < (1 << l); n++) begin
        if (l < TREE_DEPTH) begin
          cmp_nxt[(1 << l) - 1 + n] =
            $signed(qbytes[l]) > $signed(thr[(1 << l) - 1 + n]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      cmp_r <= cmp_nxt;
    end
  end

  // Stage 4: follow the path, the partial code picks the node at each level
  always_comb begin
    code_nxt = '0;
    for (int l = 0; l < thce_pkg::MaxDepth; l++) begin
      if (l < TREE_DEPTH) begin
        code_nxt = {code_nxt[thce_pkg::CodeW-2:0],
                    cmp_r[4'((1 << l) - 1) + code_nxt]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

endmodule
